@@ hdl/thermal_overtemp_hysteresis_monitor_assert.svh @@
// Assertion macros shared by the over-temperature monitor modules.
`ifndef THERMAL_OVERTEMP_HYSTERESIS_MONITOR_ASSERT_SVH
`define THERMAL_OVERTEMP_HYSTERESIS_MONITOR_ASSERT_SVH

// Property that holds in the same cycle, sampled on clk, off during reset.
`define TOHM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define TOHM_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tohm_pkg.sv @@
// Shared types and constants of the over-temperature monitor.
package tohm_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int TEMP_WIDTH_DEF   = 16;
	localparam int COUNT_W          = 8;
	localparam int CHANNEL_W        = 4;
	localparam int MASK_W           = 16;
	localparam int CFG_IDX_W        = 1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd3;

	// Request opcodes
	localparam logic OP_SAMPLE     = 1'b0;
	localparam logic OP_LOAD_LIMIT = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OVER_TEMP_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_ERR_LIMIT  = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] over_temp_count_limit;
		logic [COUNT_W-1:0] read_error_count_limit;
	} cfg_t;

	// Outcome of one saturating hysteresis step
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               set;
		logic               clr;
	} hyst_res_t;

endpackage

@@ hdl/thermal_overtemp_hysteresis_monitor.sv @@
// Top level of the over-temperature and read-error monitor.
//
//  channel   direction  handshake            payload
//  request   in         in_valid / in_ready  opcode, channel, value, sample_valid
//  result    out        out_valid/out_ready  channel_warning_mask, read_error_flag,
//                                            stored_temp
//  config    in         cfg_we               cfg_index, cfg_wdata
//
// One request per cycle unless out_ready stalls; the result is registered.
// The per-request path is a compare and two saturating counter steps in tohm_core.
// A stalled result holds in the result register while one more request waits in the
// input register; in_ready drops only when both are full.
// Reset clears all counters and warnings and disables every channel limit.
`include "thermal_overtemp_hysteresis_monitor_assert.svh"

module thermal_overtemp_hysteresis_monitor #(
	parameter int NUM_CHANNELS = tohm_pkg::NUM_CHANNELS_DEF,
	parameter int TEMP_WIDTH   = tohm_pkg::TEMP_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [tohm_pkg::CHANNEL_W-1:0]     channel,
	input  logic signed [TEMP_WIDTH-1:0]       value,
	input  logic                               sample_valid,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tohm_pkg::MASK_W-1:0]        channel_warning_mask,
	output logic                               read_error_flag,
	output logic signed [TEMP_WIDTH-1:0]       stored_temp,
	input  logic                               cfg_we,
	input  logic [tohm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tohm_pkg::COUNT_W-1:0]       cfg_wdata
);

	tohm_pkg::cfg_t                    cfg_q;

	logic                              vld_s1;
	logic                              op_s1;
	logic [tohm_pkg::CHANNEL_W-1:0]    ch_s1;
	logic signed [TEMP_WIDTH-1:0]      value_s1;
	logic                              sv_s1;

	logic                              vld_s2;
	logic [NUM_CHANNELS-1:0]           mask_s2;
	logic                              err_s2;
	logic signed [TEMP_WIDTH-1:0]      temp_s2;

	logic                              adv;
	logic [NUM_CHANNELS-1:0]           mask_nxt;
	logic                              err_nxt;
	logic signed [TEMP_WIDTH-1:0]      shown_nxt;
	logic [tohm_pkg::MASK_W+NUM_CHANNELS-1:0] mask_ext;

	// Handshake: stage 1 moves on whenever the result register is free or emptying
	assign adv      = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.over_temp_count_limit  <= tohm_pkg::COUNT_RESET;
			cfg_q.read_error_count_limit <= tohm_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tohm_pkg::CFG_OVER_TEMP_LIMIT: cfg_q.over_temp_count_limit  <= cfg_wdata;
				tohm_pkg::CFG_READ_ERR_LIMIT:  cfg_q.read_error_count_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= opcode;
			ch_s1    <= channel;
			value_s1 <= value;
			sv_s1    <= sample_valid;
		end
	end

	tohm_core #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TEMP_WIDTH   (TEMP_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (adv),
		.op           (op_s1),
		.channel      (ch_s1),
		.value        (value_s1),
		.sample_valid (sv_s1),
		.cfg          (cfg_q),
		.mask_nxt     (mask_nxt),
		.err_nxt      (err_nxt),
		.shown_nxt    (shown_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv)
			vld_s2 <= 1'b1;
		else if (out_ready)
			vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s2 <= mask_nxt;
			err_s2  <= err_nxt;
			temp_s2 <= shown_nxt;
		end
	end

	assign mask_ext             = {tohm_pkg::MASK_W'(0), mask_s2};
	assign channel_warning_mask = mask_ext[tohm_pkg::MASK_W-1:0];
	assign read_error_flag      = err_s2;
	assign stored_temp          = temp_s2;
	assign out_valid            = vld_s2;

	// A request handed to the core shows up as a result next cycle
	`TOHM_ASSERT_NEXT(a_adv_result, adv, vld_s2, "stepped request produced no result")
	// A blocked request stays in the input register
	`TOHM_ASSERT_NEXT(a_s1_hold, vld_s1 && vld_s2 && !out_ready, vld_s1 && $stable(value_s1) && $stable(ch_s1), "blocked request lost")
	// The input register is full whenever the request port is closed
	`TOHM_ASSERT(a_ready_full, !in_ready |-> (vld_s1 && vld_s2), "request port closed with room free")

endmodule

@@ hdl/tohm_hyst.sv @@
// Saturating up/down hysteresis counter step.
module tohm_hyst (
	input  logic [tohm_pkg::COUNT_W-1:0] count,
	input  logic                         up,
	input  logic [tohm_pkg::COUNT_W-1:0] top,
	output tohm_pkg::hyst_res_t          res
);

	localparam int SW = tohm_pkg::COUNT_W + 2;

	logic signed [SW-1:0] stepped;
	logic signed [SW-1:0] top_ext;

	// Step by one, then clamp; the top test wins, so with a zero top an up step sets
	always_comb begin
		stepped = $signed({2'b00, count}) + (up ? SW'(1) : -SW'(1));
		top_ext = $signed({2'b00, top});
		res     = '0;
		if (stepped >= top_ext) begin
			res.count = top;
			res.set   = 1'b1;
		end else if (stepped <= SW'(0)) begin
			res.count = '0;
			res.clr   = 1'b1;
		end else begin
			res.count = stepped[tohm_pkg::COUNT_W-1:0];
		end
	end

endmodule

@@ hdl/tohm_core.sv @@
// Channel tables, hysteresis counters and warning state, updated once per request.
`include "thermal_overtemp_hysteresis_monitor_assert.svh"

module tohm_core #(
	parameter int NUM_CHANNELS = tohm_pkg::NUM_CHANNELS_DEF,
	parameter int TEMP_WIDTH   = tohm_pkg::TEMP_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step_en,
	input  logic                              op,
	input  logic [tohm_pkg::CHANNEL_W-1:0]    channel,
	input  logic signed [TEMP_WIDTH-1:0]      value,
	input  logic                              sample_valid,
	input  tohm_pkg::cfg_t                    cfg,
	output logic [NUM_CHANNELS-1:0]           mask_nxt,
	output logic                              err_nxt,
	output logic signed [TEMP_WIDTH-1:0]      shown_nxt
);

	localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic signed [TEMP_WIDTH-1:0] TEMP_MAX = {1'b0, {(TEMP_WIDTH-1){1'b1}}};

	logic signed [TEMP_WIDTH-1:0]      limit_q [NUM_CHANNELS];
	logic signed [TEMP_WIDTH-1:0]      temp_q  [NUM_CHANNELS];
	logic [tohm_pkg::COUNT_W-1:0]      over_cnt_q [NUM_CHANNELS];
	logic [tohm_pkg::COUNT_W-1:0]      err_cnt_q;
	logic [NUM_CHANNELS-1:0]           warn_q;
	logic                              err_bit_q;

	logic [CH_IW+tohm_pkg::CHANNEL_W-1:0] ch_ext;
	logic [CH_IW-1:0]                  ch_idx;
	logic                              in_range;
	logic                              is_sample;
	logic                              good_sample;
	logic signed [TEMP_WIDTH-1:0]      lim_rd;
	logic signed [TEMP_WIDTH-1:0]      temp_rd;
	logic [tohm_pkg::COUNT_W-1:0]      cnt_rd;
	logic                              trip;
	tohm_pkg::hyst_res_t               err_res;
	tohm_pkg::hyst_res_t               ch_res;

	// Channel decode
	assign ch_ext      = {CH_IW'(0), channel};
	assign ch_idx      = ch_ext[CH_IW-1:0];
	assign in_range    = ({28'd0, channel} < 32'(NUM_CHANNELS));
	assign is_sample   = in_range && (op == tohm_pkg::OP_SAMPLE);
	assign good_sample = is_sample && sample_valid;

	// Table reads for the addressed channel
	assign lim_rd  = in_range ? limit_q[ch_idx]    : TEMP_MAX;
	assign temp_rd = in_range ? temp_q[ch_idx]     : '0;
	assign cnt_rd  = in_range ? over_cnt_q[ch_idx] : '0;

	// Disabled limit never trips
	assign trip = (lim_rd != TEMP_MAX) && (value >= lim_rd);

	tohm_hyst u_err_hyst (
		.count (err_cnt_q),
		.up    (!sample_valid),
		.top   (cfg.read_error_count_limit),
		.res   (err_res)
	);

	tohm_hyst u_ch_hyst (
		.count (cnt_rd),
		.up    (trip),
		.top   (cfg.over_temp_count_limit),
		.res   (ch_res)
	);

	// State after this request
	always_comb begin
		err_nxt = err_bit_q;
		if (is_sample) begin
			if (err_res.set)
				err_nxt = 1'b1;
			else if (err_res.clr)
				err_nxt = 1'b0;
		end
		mask_nxt = warn_q;
		if (good_sample) begin
			if (ch_res.set)
				mask_nxt[ch_idx] = 1'b1;
			else if (ch_res.clr)
				mask_nxt[ch_idx] = 1'b0;
		end
		if (!in_range)
			shown_nxt = '0;
		else if (good_sample)
			shown_nxt = value;
		else
			shown_nxt = temp_rd;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				limit_q[i]    <= TEMP_MAX;
				temp_q[i]     <= '0;
				over_cnt_q[i] <= '0;
			end
			err_cnt_q <= '0;
			warn_q    <= '0;
			err_bit_q <= 1'b0;
		end else if (step_en) begin
			warn_q    <= mask_nxt;
			err_bit_q <= err_nxt;
			if (in_range && (op == tohm_pkg::OP_LOAD_LIMIT))
				limit_q[ch_idx] <= value;
			if (is_sample)
				err_cnt_q <= err_res.count;
			if (good_sample) begin
				temp_q[ch_idx]     <= value;
				over_cnt_q[ch_idx] <= ch_res.count;
			end
		end
	end

	// Warning state only moves on a request step
	`TOHM_ASSERT_NEXT(a_warn_hold, !step_en, $stable(warn_q) && $stable(err_bit_q), "warning state moved without a request")
	// A limit load never touches the warnings
	`TOHM_ASSERT_NEXT(a_load_quiet, step_en && (op == tohm_pkg::OP_LOAD_LIMIT), $stable(warn_q) && $stable(err_bit_q), "limit load changed warning state")

endmodule
